@@ hw/rtl/srct_pkg.sv @@
// ----------------------------------------------------------------------------
// srct_pkg: shared types for the session replay counter table
// Field widths, slot count, item kinds and the structs that travel along the
// chain of slot cells.
// ----------------------------------------------------------------------------
package srct_pkg;

    localparam int SLOTS = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [31:0]      t_session;
    typedef logic [31:0]      t_counter;
    typedef logic [IDX_W-1:0] t_idx;

    localparam logic KIND_CHECK   = 1'b0;
    localparam logic KIND_RESTORE = 1'b1;

    // Lookup token that walks the chain, one cell per cycle.
    typedef struct packed {
        logic     valid;
        logic     kind;
        t_session sess;
        t_counter counter;
        logic     hit;       // a valid slot with this session was seen
        t_idx     hit_idx;
        logic     hit_gt;    // new counter is above the hit slot's counter
        logic     free;      // an empty slot was seen
        t_idx     free_idx;  // lowest empty slot
    } t_token;

    // Slot write broadcast to all cells.
    typedef struct packed {
        logic     en;
        t_idx     idx;
        t_session sess;
        t_counter counter;
    } t_wr;

endpackage

@@ hw/rtl/srct_if.sv @@
// ----------------------------------------------------------------------------
// srct_in_if / srct_out_if: valid-ready channels of the table
// One beat moves on a rising edge at which valid and ready are both high.
// ----------------------------------------------------------------------------
interface srct_in_if;
    import srct_pkg::*;

    logic     valid;
    logic     ready;
    logic     kind;
    t_session sess;
    t_counter counter;

    modport source (output valid, output kind, output sess, output counter,
                    input ready);
    modport sink   (input valid, input kind, input sess, input counter,
                    output ready);
endinterface

interface srct_out_if;
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, output accepted, input ready);
    modport sink   (input valid, input accepted, output ready);
endinterface

@@ hw/rtl/srct_cell.sv @@
// ----------------------------------------------------------------------------
// srct_cell: one slot of the replay table
// Holds a slot and compares it against the lookup token passing through.
// ----------------------------------------------------------------------------
module srct_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srct_pkg::t_idx   i_index,
    input  srct_pkg::t_token i_token,
    input  srct_pkg::t_wr    i_wr,
    output srct_pkg::t_token o_token
);
    import srct_pkg::*;

    logic     r_valid;
    t_session r_session;
    t_counter r_counter;
    t_token   r_token;
    t_token   n_token;
    logic     w_match;

    assign w_match = r_valid && (r_session == i_token.sess);

    // Only the first match and the first empty slot are recorded.
    always_comb begin
        n_token = i_token;
        if (w_match && !i_token.hit) begin
            n_token.hit     = 1'b1;
            n_token.hit_idx = i_index;
            n_token.hit_gt  = i_token.counter > r_counter;
        end
        if (!r_valid && !i_token.free) begin
            n_token.free     = 1'b1;
            n_token.free_idx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_token.valid <= 1'b0;
        end else begin
            r_token <= n_token;
            if (i_wr.en && (i_wr.idx == i_index)) begin
                r_valid <= 1'b1;
            end
        end
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_session <= i_wr.sess;
            r_counter <= i_wr.counter;
        end
    end

    assign o_token = r_token;

endmodule

@@ hw/rtl/session_replay_counter_table.sv @@
// ----------------------------------------------------------------------------
// session_replay_counter_table: anti-replay table, highest counter per session
// A row of slot cells searched by a token that walks the row.
// ----------------------------------------------------------------------------
// Each input beat carries a kind, a session and a counter, and yields exactly
// one output beat with an accept flag. The table holds SLOTS slots, all empty
// after reset. A lookup prefers a valid slot with the same session anywhere in
// the table, and otherwise takes the lowest empty slot; with no match and no
// empty slot the beat is rejected. A check fills a new slot and accepts, or on
// an existing slot accepts only a strictly larger counter and records it. A
// restore writes the counter unconditionally and accepts. A zero counter is
// always rejected and changes nothing. A new beat is taken only in idle: the
// lookup token moves through one slot cell per cycle, the slot write and the
// result happen as it leaves the last cell, and the controller then returns
// to idle before it takes the next beat. The output register lets a new item
// start while the previous result still waits to be taken; a second result
// that finds the register still full holds the input off until it moves in.
// ----------------------------------------------------------------------------
module session_replay_counter_table (
    input logic      i_clk,
    input logic      i_rst_n,
    srct_in_if.sink   i_in,
    srct_out_if.source o_out
);
    import srct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_acc;
    logic   r_pend;

    t_token w_tok [SLOTS+1];
    t_wr    w_wr;
    logic   w_acc;
    t_token w_last;
    logic   w_load;

    // The token enters the first cell on the accepting edge; the search flags
    // start clear.
    always_comb begin
        w_tok[0]         = '0;
        w_tok[0].valid   = i_in.valid && i_in.ready;
        w_tok[0].kind    = i_in.kind;
        w_tok[0].sess    = i_in.sess;
        w_tok[0].counter = i_in.counter;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        srct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_token (w_tok[g]),
            .i_wr    (w_wr),
            .o_token (w_tok[g+1])
        );
    end

    assign w_last = w_tok[SLOTS];

    // Decision once the token has seen every slot. A matching slot wins over
    // an empty one. A restore, or a check on a new slot, writes session and
    // counter; a check on an existing slot writes only when the counter grows
    // (the session is rewritten with the same value).
    always_comb begin
        w_wr         = '0;
        w_wr.idx     = w_last.hit ? w_last.hit_idx : w_last.free_idx;
        w_wr.sess    = w_last.sess;
        w_wr.counter = w_last.counter;
        w_acc        = 1'b0;
        if (w_last.valid && (w_last.counter != '0) && (w_last.hit || w_last.free)) begin
            if ((w_last.kind == KIND_RESTORE) || !w_last.hit || w_last.hit_gt) begin
                w_wr.en = 1'b1;
                w_acc   = 1'b1;
            end
        end
    end

    // A result moves into the output register when the lookup ends, or later
    // from the hold state, as soon as the register is empty or being emptied.
    assign w_load = ((r_state == S_WALK && w_last.valid) || (r_state == S_HOLD)) &&
                    (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_load || (r_out_valid && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_last.valid) begin
                        if (w_load) begin
                            r_acc   <= w_acc;
                            r_state <= S_IDLE;
                        end else begin
                            r_pend  <= w_acc;
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    // The slot is already written; only the result waits.
                    if (w_load) begin
                        r_acc   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.accepted = r_acc;

endmodule

@@ bench/session_replay_counter_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_replay_counter_table_tb: self-checking bench for the replay table
// Offers check and restore beats, first from a short table of edge cases, then
// at random, and checks every accept flag against its row or a predictor that
// keeps its own copy of the slots. Both channels idle at random, and the result
// side holds off once for a long stretch so that the table backs up its input.
// ----------------------------------------------------------------------------
module session_replay_counter_table_tb;
    import srct_pkg::*;

    localparam int N_DIRECTED   = 23;
    localparam int N_RANDOM     = 480;
    localparam int N_TOTAL      = N_DIRECTED + N_RANDOM;
    localparam int IDLE_PCT     = 15;
    // Items in this window are offered and drained with no idling at all.
    localparam int CALM_FIRST   = 250;
    localparam int CALM_LAST    = 350;
    // The result side stops taking beats once this many items are in.
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 64;
    // Slowest correct gap between beats is the hold-off plus one lookup pass.
    localparam int WATCHDOG_MAX = 1000;
    localparam int TAIL_CYCLES  = 4 * (SLOTS + 1);

    typedef struct packed {
        logic     kind;
        t_session sess;
        t_counter counter;
    } t_req;

    // One row of the directed part. When typed is set, accepted is the flag
    // the row must produce; otherwise the predictor supplies it.
    typedef struct packed {
        t_req req;
        logic typed;
        logic accepted;
    } t_row;

    typedef struct {
        int unsigned seq;
        logic        accepted;
    } t_verdict;

    // Edge cases in order. The table starts empty, fills up in rows 2 to 17
    // and stays full for the rest of the run, since slots are never freed.
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Zero counter on an empty table, for both kinds.
        '{'{KIND_CHECK,   32'h0000_0000, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{KIND_RESTORE, 32'h0000_0000, 32'h0000_0000}, 1'b1, 1'b0},
        // Session 0 takes the lowest free slot, then sees a repeat.
        '{'{KIND_CHECK,   32'h0000_0000, 32'h0000_0001}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'h0000_0000, 32'h0000_0001}, 1'b1, 1'b0},
        // Largest counter, then a stale one just below it.
        '{'{KIND_CHECK,   32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'h0000_0000, 32'hFFFF_FFFE}, 1'b1, 1'b0},
        // A restore may move the counter down.
        '{'{KIND_RESTORE, 32'h0000_0000, 32'h0000_0005}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'h0000_0000, 32'h0000_0006}, 1'b0, 1'b0},
        // All-ones session, zero counter on a live slot, restore to the same value.
        '{'{KIND_CHECK,   32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{KIND_RESTORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 1'b1},
        // A restore on a new session allocates a slot.
        '{'{KIND_RESTORE, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'hAAAA_AAAA, 32'h5555_5555}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'h5555_5555, 32'hAAAA_AAAB}, 1'b0, 1'b0},
        // Fill the remaining slots.
        '{'{KIND_CHECK,   32'h0000_0001, 32'h0000_0001}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'h0000_0002, 32'h0000_0001}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'h0000_0003, 32'h0000_0001}, 1'b1, 1'b1},
        '{'{KIND_CHECK,   32'h0000_0004, 32'h0000_0001}, 1'b1, 1'b1},
        // Table full: a new session is turned away for both kinds.
        '{'{KIND_CHECK,   32'h0000_0006, 32'h0000_0007}, 1'b1, 1'b0},
        '{'{KIND_RESTORE, 32'h0000_0006, 32'h0000_0007}, 1'b1, 1'b0},
        // A known session still matches while the table is full.
        '{'{KIND_CHECK,   32'h0000_0001, 32'h0000_0002}, 1'b0, 1'b0},
        // A zero restore must leave session 0 untouched.
        '{'{KIND_RESTORE, 32'h0000_0000, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{KIND_CHECK,   32'h0000_0000, 32'h0000_0007}, 1'b0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    srct_in_if  in_ch();
    srct_out_if out_ch();

    session_replay_counter_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted contents of the table.
    logic     slot_used [SLOTS] = '{default: 1'b0};
    t_session slot_sid  [SLOTS] = '{default: '0};
    t_counter slot_top  [SLOTS] = '{default: '0};

    t_verdict    verdicts [$];          // accept flags still owed by the block
    t_req        cur_req      = '0;     // item on offer, or next to be offered
    logic        cur_typed    = 1'b0;
    logic        cur_expected = 1'b0;
    logic        have_req     = 1'b0;
    int unsigned stim_idx     = 0;      // items taken from the stimulus so far
    int unsigned beats_in     = 0;      // input beats accepted, updated at the edge
    int unsigned idle_cycles  = 0;
    int unsigned errors       = 0;
    logic        calm         = 1'b0;
    logic        hold_off     = 1'b0;
    logic        drained      = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Applies one item to the predicted table and returns its accept flag.
    // A matching session wins over a free slot wherever it sits.
    function automatic logic update_table(input t_req r);
        int i;
        int hit_idx;
        int free_idx;
        hit_idx  = -1;
        free_idx = -1;
        if (r.counter == '0) return 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_sid[i] == r.sess && hit_idx < 0) hit_idx = i;
            if (!slot_used[i] && free_idx < 0) free_idx = i;
        end
        if (hit_idx >= 0) begin
            if (r.kind == KIND_RESTORE || r.counter > slot_top[hit_idx]) begin
                slot_top[hit_idx] = r.counter;
                return 1'b1;
            end
            return 1'b0;
        end
        if (free_idx >= 0) begin
            slot_used[free_idx] = 1'b1;
            slot_sid[free_idx]  = r.sess;
            slot_top[free_idx]  = r.counter;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Favours well-formed traffic: live sessions, and counters just above the
    // stored one. The rest is repeats, stale and zero counters, wild values,
    // near-maximum counters and unknown sessions.
    function automatic t_req random_req();
        t_req        r;
        int unsigned pick;
        int unsigned s;
        int          i;
        t_counter    base;
        base   = '0;
        pick   = $urandom_range(0, 99);
        s      = $urandom_range(0, SLOTS - 1);
        r.kind = ($urandom_range(0, 99) < 15) ? KIND_RESTORE : KIND_CHECK;
        if (pick < 80 && slot_used[s]) r.sess = slot_sid[s];
        else                           r.sess = $urandom();
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_sid[i] == r.sess) base = slot_top[i];
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)      r.counter = base + $urandom_range(1, 3);
        else if (pick < 65) r.counter = base;
        else if (pick < 75) r.counter = base - $urandom_range(1, 16);
        else if (pick < 83) r.counter = '0;
        else if (pick < 93) r.counter = $urandom();
        else                r.counter = 32'hFFFF_FFFF - $urandom_range(0, 3);
        // Small restores pull sessions back down after they reach the top.
        if (r.kind == KIND_RESTORE && pick < 55) r.counter = $urandom_range(1, 1000);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // One process owns both channels, so predicting an item, queuing its flag
    // and checking a returned flag never race each other within a time step.
    always @(posedge i_clk) begin : bench_step
        t_verdict v;
        logic     got;
        logic     offer;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            // Result side: compare the beat with the oldest owed flag.
            if (out_ch.valid && out_ch.ready) begin
                if (verdicts.size() == 0) begin
                    report_mismatch($sformatf("accept flag %0b with no item outstanding",
                                              out_ch.accepted));
                end else begin
                    v = verdicts.pop_front();
                    if (out_ch.accepted !== v.accepted) begin
                        report_mismatch($sformatf("item %0d: accepted %0b, expected %0b",
                                                  v.seq, out_ch.accepted, v.accepted));
                    end
                end
            end

            // Item side: an accepted beat updates the predicted table at once,
            // so the next random item already sees its effect.
            if (in_ch.valid && in_ch.ready) begin
                got        = update_table(cur_req);
                v.seq      = beats_in;
                v.accepted = cur_typed ? cur_expected : got;
                verdicts.push_back(v);
                beats_in <= beats_in + 1;
                have_req = 1'b0;
            end
            if (!have_req && stim_idx < N_TOTAL) begin
                if (stim_idx < N_DIRECTED) begin
                    cur_req      = DIRECTED_ROWS[stim_idx].req;
                    cur_typed    = DIRECTED_ROWS[stim_idx].typed;
                    cur_expected = DIRECTED_ROWS[stim_idx].accepted;
                end else begin
                    cur_req   = random_req();
                    cur_typed = 1'b0;
                end
                stim_idx++;
                have_req = 1'b1;
            end

            // A beat on offer stays on offer until it is taken.
            if (in_ch.valid && !in_ch.ready) offer = 1'b1;
            else offer = have_req && (calm || $urandom_range(0, 99) >= IDLE_PCT);
            in_ch.valid   <= offer;
            in_ch.kind    <= cur_req.kind;
            in_ch.sess    <= cur_req.sess;
            in_ch.counter <= cur_req.counter;
            out_ch.ready  <= !hold_off && (calm || $urandom_range(0, 99) >= IDLE_PCT);

            calm    <= (stim_idx >= CALM_FIRST && stim_idx < CALM_LAST);
            drained <= !have_req && stim_idx == N_TOTAL && verdicts.size() == 0;
        end

        // Watchdog: any beat on either channel counts as progress.
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_MAX);
            $display("session_replay_counter_table_tb: FAIL");
            $finish;
        end
    end

    // Long hold-off on the result side while the sender keeps offering items:
    // the output register fills, the next lookup finishes, and input stalls.
    initial begin : result_hold_off
        while (beats_in < HOLD_AT) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : run
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_CHECK;
        in_ch.sess    = '0;
        in_ch.counter = '0;
        out_ch.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!drained) @(posedge i_clk);
        // Give a misbehaving block time to emit extra results.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d accept flags never arrived", verdicts.size()));
        end
        if (errors == 0) begin
            $display("session_replay_counter_table_tb: PASS");
        end else begin
            $display("session_replay_counter_table_tb: FAIL");
        end
        $finish;
    end

endmodule
